// ===== hw/rtl/iair_pkg.sv =====
// Package for the indexed array insert/remove block.
// Holds sizes, command/status codes, sequencer states and payload structs.
// No dependencies.
package iair_pkg;

  localparam int CAPACITY = 64;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int LEN_W    = 7;

  typedef enum logic [2:0] {
    CMD_INSERT    = 3'd0,
    CMD_REMOVE    = 3'd1,
    CMD_READ      = 3'd2,
    CMD_WRITE     = 3'd3,
    CMD_REM_SLICE = 3'd4,
    CMD_SET_LEN   = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_READ,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]              command;
    logic [LEN_W-1:0]        index;
    logic [LEN_W-1:0]        end_index;
    logic signed [31:0]      value;
    logic [LEN_W-1:0]        new_length;
  } in_t;

  typedef struct packed {
    logic signed [31:0]      read_value;
    status_t                 status;
    logic [LEN_W-1:0]        length;
  } out_t;

endpackage

// ===== hw/rtl/indexed_array_insert_remove.sv =====
// Indexed array store with insert/remove/slice/read/write/set-length commands.
// Single-port-write, registered-read memory driven by a small shift sequencer.
// Depends on iair_pkg.
//
//  channel | dir | signals                         | transfer when
//  --------+-----+---------------------------------+--------------------------
//  in      | in  | in_valid, in_ready, in_data     | in_valid & in_ready
//  out     | out | out_valid, out_ready, out_data  | out_valid & out_ready
//
// Commands: one at a time. Insert moves (length - index) entries up, then writes the
// new value; remove or slice removal moves (length - end) entries down. Entries move
// one per cycle through the memory's single write port and one shared pointer stepper.
// Reset: synchronous; afterwards a clearing pass zeroes all CAPACITY (64) entries of
// the store, with in_ready low.
// Stalls: the result sits in an output register; a held result only delays the
// end of the following command, never its start.
module indexed_array_insert_remove (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  iair_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output iair_pkg::out_t  out_data
);

  localparam int AW = iair_pkg::ADDR_W;
  localparam int LW = iair_pkg::LEN_W;
  localparam int DW = iair_pkg::DATA_W;

  // element store
  logic [DW-1:0] mem [iair_pkg::CAPACITY];

  iair_pkg::state_t  state, state_next;
  logic [LW-1:0]     count;
  logic [AW-1:0]     clr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [AW-1:0]     wr_ptr;
  logic [LW-1:0]     moves;
  logic              shift_up;
  logic              pend_valid;
  logic [AW-1:0]     pend_addr;
  logic [DW-1:0]     rd_data;
  logic [AW-1:0]     ins_addr;
  logic [DW-1:0]     ins_value;
  logic [DW-1:0]     res_value;
  iair_pkg::status_t res_status;

  // memory port controls
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DW-1:0]     mem_wdata;
  logic [AW-1:0]     mem_raddr;

  // shared pointer stepper: +1 for removal, -1 for insert
  logic [AW-1:0]     step;
  logic [AW-1:0]     rd_ptr_stepped;
  logic [AW-1:0]     wr_ptr_stepped;

  // command decode, evaluated against the current length
  iair_pkg::status_t dec_status;
  iair_pkg::state_t  dec_next;
  logic [LW-1:0]     dec_count;
  logic [LW-1:0]     dec_moves;
  logic [LW-1:0]     dec_rd;
  logic [LW-1:0]     dec_wr;
  logic              dec_up;
  logic [LW-1:0]     slice_end;

  logic accept;
  logic out_load;

  assign in_ready = (state == iair_pkg::S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state == iair_pkg::S_FINISH) && (!out_valid || out_ready);

  assign step           = shift_up ? {AW{1'b1}} : AW'(1);
  assign rd_ptr_stepped = rd_ptr + step;
  assign wr_ptr_stepped = wr_ptr + step;

  // remove of one entry is a slice of length one
  assign slice_end = (in_data.command == iair_pkg::CMD_REMOVE) ?
                     (in_data.index + LW'(1)) : in_data.end_index;

  always_comb begin
    dec_status = iair_pkg::ST_OK;
    dec_next   = iair_pkg::S_FINISH;
    dec_count  = count;
    dec_moves  = '0;
    dec_rd     = '0;
    dec_wr     = '0;
    dec_up     = 1'b0;
    unique case (in_data.command)
      iair_pkg::CMD_INSERT: begin
        if (in_data.index > count) begin
          dec_status = iair_pkg::ST_BAD;
        end else if (count >= LW'(iair_pkg::CAPACITY)) begin
          dec_status = iair_pkg::ST_FULL;
        end else begin
          dec_count = count + LW'(1);
          dec_moves = count - in_data.index;
          dec_rd    = count - LW'(1);
          dec_wr    = count;
          dec_up    = 1'b1;
          dec_next  = (dec_moves != '0) ? iair_pkg::S_SHIFT : iair_pkg::S_PUT;
        end
      end
      iair_pkg::CMD_REMOVE, iair_pkg::CMD_REM_SLICE: begin
        if (in_data.index >= count || slice_end > count || slice_end <= in_data.index) begin
          dec_status = iair_pkg::ST_BAD;
        end else begin
          dec_count = count - slice_end + in_data.index;
          dec_moves = count - slice_end;
          dec_rd    = slice_end;
          dec_wr    = in_data.index;
          dec_next  = (dec_moves != '0) ? iair_pkg::S_SHIFT : iair_pkg::S_FINISH;
        end
      end
      iair_pkg::CMD_READ: begin
        if (in_data.index >= count) begin
          dec_status = iair_pkg::ST_BAD;
        end else begin
          dec_next = iair_pkg::S_READ;
        end
      end
      iair_pkg::CMD_WRITE: begin
        if (in_data.index >= count) begin
          dec_status = iair_pkg::ST_BAD;
        end else begin
          dec_next = iair_pkg::S_PUT;
        end
      end
      iair_pkg::CMD_SET_LEN: begin
        if (in_data.new_length > LW'(iair_pkg::CAPACITY)) begin
          dec_status = iair_pkg::ST_FULL;
        end else begin
          dec_count = in_data.new_length;
        end
      end
      default: begin
        dec_status = iair_pkg::ST_BAD;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      iair_pkg::S_CLEAR: begin
        if (clr_ptr == AW'(iair_pkg::CAPACITY - 1)) state_next = iair_pkg::S_IDLE;
      end
      iair_pkg::S_IDLE: begin
        if (accept) state_next = dec_next;
      end
      iair_pkg::S_SHIFT: begin
        if (moves == LW'(1)) state_next = iair_pkg::S_DRAIN;
      end
      iair_pkg::S_DRAIN: begin
        state_next = shift_up ? iair_pkg::S_PUT : iair_pkg::S_FINISH;
      end
      iair_pkg::S_PUT: begin
        state_next = iair_pkg::S_FINISH;
      end
      iair_pkg::S_READ: begin
        state_next = iair_pkg::S_FINISH;
      end
      iair_pkg::S_FINISH: begin
        if (out_load) state_next = iair_pkg::S_IDLE;
      end
      default: begin
        state_next = iair_pkg::S_IDLE;
      end
    endcase
  end

  // memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pend_addr;
    mem_wdata = rd_data;
    mem_raddr = in_data.index[AW-1:0];
    unique case (state)
      iair_pkg::S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr;
        mem_wdata = '0;
      end
      iair_pkg::S_SHIFT: begin
        mem_we    = pend_valid;
        mem_raddr = rd_ptr;
      end
      iair_pkg::S_DRAIN: begin
        mem_we = pend_valid;
      end
      iair_pkg::S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = ins_addr;
        mem_wdata = ins_value;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[mem_raddr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= iair_pkg::S_CLEAR;
      clr_ptr    <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      pend_valid <= (state == iair_pkg::S_SHIFT);
      if (state == iair_pkg::S_CLEAR) begin
        clr_ptr <= clr_ptr + AW'(1);
      end
      if (accept) begin
        count <= dec_count;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_ptr     <= dec_rd[AW-1:0];
      wr_ptr     <= dec_wr[AW-1:0];
      moves      <= dec_moves;
      shift_up   <= dec_up;
      ins_addr   <= in_data.index[AW-1:0];
      ins_value  <= in_data.value;
      res_value  <= '0;
      res_status <= dec_status;
    end
    if (state == iair_pkg::S_SHIFT) begin
      rd_ptr    <= rd_ptr_stepped;
      wr_ptr    <= wr_ptr_stepped;
      moves     <= moves - LW'(1);
      pend_addr <= wr_ptr;
    end
    if (state == iair_pkg::S_READ) begin
      res_value <= rd_data;
    end
    if (out_load) begin
      out_data.read_value <= res_value;
      out_data.status     <= res_status;
      out_data.length     <= count;
    end
  end

  // checks
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= LW'(iair_pkg::CAPACITY))
    else $error("length exceeds capacity");

  a_no_raw_hazard: assert property (@(posedge clk) disable iff (rst)
    (state == iair_pkg::S_SHIFT && pend_valid) |-> (pend_addr != rd_ptr))
    else $error("shift reads the entry being written");

  a_reject_keeps_len: assert property (@(posedge clk) disable iff (rst)
    (accept && dec_status != iair_pkg::ST_OK) |=> (count == $past(count)))
    else $error("rejected command changed length");

  a_result_len: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && out_data.length == $past(count)))
    else $error("result length mismatch");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for indexed_array_insert_remove: directed table, then random commands.
// Depends on iair_pkg and the indexed_array_insert_remove RTL.
module testbench;

  // Command codes the block does not define; it must reject them with bad index.
  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  localparam int LW           = iair_pkg::LEN_W;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 32;  // extra wait after the last result; a stray result in it is flagged

  // One row of the directed table. When fixed is set, want holds the expected result
  // typed in by hand; otherwise the array model supplies it.
  typedef struct {
    iair_pkg::in_t  cmd;
    bit             fixed;
    iair_pkg::out_t want;
  } row_t;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_ready;
  iair_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  iair_pkg::out_t out_data;

  // Array model: contents and current length, updated once per accepted command.
  logic signed [iair_pkg::DATA_W-1:0] model_store [iair_pkg::CAPACITY];
  int unsigned                        model_len;

  iair_pkg::out_t pending_results [$];
  row_t           directed [$];
  int             failures = 0;

  indexed_array_insert_remove dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Hard stop, several times the slowest legal run (every command a full shift
  // plus the longest gaps on both sides).
  initial begin
    #10_000_000;
    $display("FAIL indexed_array_insert_remove");
    $finish;
  end

  // Apply one command to the array model and return the result it must produce.
  function automatic iair_pkg::out_t apply_command(iair_pkg::in_t c);
    iair_pkg::out_t r;
    int unsigned    i;
    int unsigned    idx;
    int unsigned    stop;
    int unsigned    gap;
    idx  = c.index;
    stop = c.end_index;
    r.read_value = '0;
    r.status     = iair_pkg::ST_OK;
    case (c.command)
      iair_pkg::CMD_INSERT: begin
        // index check comes before the capacity check
        if (idx > model_len) begin
          r.status = iair_pkg::ST_BAD;
        end else if (model_len + 1 > iair_pkg::CAPACITY) begin
          r.status = iair_pkg::ST_FULL;
        end else begin
          for (i = model_len; i > idx; i--) model_store[i] = model_store[i-1];
          model_store[idx] = c.value;
          model_len++;
        end
      end
      iair_pkg::CMD_REMOVE: begin
        if (idx >= model_len) begin
          r.status = iair_pkg::ST_BAD;
        end else begin
          for (i = idx; i + 1 < model_len; i++) model_store[i] = model_store[i+1];
          model_len--;
        end
      end
      iair_pkg::CMD_READ: begin
        if (idx >= model_len) r.status = iair_pkg::ST_BAD;
        else r.read_value = model_store[idx];
      end
      iair_pkg::CMD_WRITE: begin
        if (idx >= model_len) r.status = iair_pkg::ST_BAD;
        else model_store[idx] = c.value;
      end
      iair_pkg::CMD_REM_SLICE: begin
        if (idx >= model_len || stop > model_len || stop <= idx) begin
          r.status = iair_pkg::ST_BAD;
        end else begin
          gap = stop - idx;
          for (i = idx; i + gap < model_len; i++) model_store[i] = model_store[i+gap];
          model_len -= gap;
        end
      end
      iair_pkg::CMD_SET_LEN: begin
        // lengthening exposes stale contents, nothing is cleared
        if (c.new_length > iair_pkg::CAPACITY) r.status = iair_pkg::ST_FULL;
        else model_len = c.new_length;
      end
      default: r.status = iair_pkg::ST_BAD;
    endcase
    r.length = LW'(model_len);
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, int idx, int stop, logic [31:0] val,
                                  int nlen, bit fixed, logic [31:0] rv,
                                  iair_pkg::status_t st, int len);
    row_t r;
    r.cmd.command         = op;
    r.cmd.index           = LW'(idx);
    r.cmd.end_index       = LW'(stop);
    r.cmd.value           = val;
    r.cmd.new_length      = LW'(nlen);
    r.fixed               = fixed;
    r.want.read_value     = rv;
    r.want.status         = st;
    r.want.length         = LW'(len);
    directed.push_back(r);
  endfunction

  // Random command shaped on the model's current length: mostly in-range indexes and
  // well-formed slices so the shifting paths get exercised, plus noise.
  function automatic iair_pkg::in_t random_command();
    iair_pkg::in_t c;
    int unsigned   pick;
    int unsigned   top;
    c.index      = LW'($urandom);
    c.end_index  = LW'($urandom);
    c.new_length = LW'($urandom);
    c.value      = $urandom;
    case ($urandom_range(0, 9))
      0: c.value = 32'h8000_0000;
      1: c.value = 32'h7fff_ffff;
      2: c.value = 32'hffff_ffff;
      default: ;
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30)      c.command = iair_pkg::CMD_INSERT;
    else if (pick < 48) c.command = iair_pkg::CMD_REMOVE;
    else if (pick < 62) c.command = iair_pkg::CMD_READ;
    else if (pick < 76) c.command = iair_pkg::CMD_WRITE;
    else if (pick < 86) c.command = iair_pkg::CMD_REM_SLICE;
    else if (pick < 96) c.command = iair_pkg::CMD_SET_LEN;
    else                c.command = ($urandom_range(0, 1) != 0) ? CMD_SPARE_A : CMD_SPARE_B;

    // 15% of items keep fully random indexes and lengths
    if ($urandom_range(0, 99) >= 15) begin
      case (c.command)
        iair_pkg::CMD_INSERT: c.index = LW'($urandom_range(0, model_len));
        iair_pkg::CMD_REMOVE, iair_pkg::CMD_READ, iair_pkg::CMD_WRITE: begin
          if (model_len > 0) c.index = LW'($urandom_range(0, model_len - 1));
        end
        iair_pkg::CMD_REM_SLICE: begin
          if (model_len > 0) begin
            c.index = LW'($urandom_range(0, model_len - 1));
            top = model_len - c.index;
            // mostly short slices, sometimes of any length up to the end
            if ($urandom_range(0, 3) == 0) c.end_index = LW'(c.index + $urandom_range(1, top));
            else c.end_index = LW'(c.index + $urandom_range(1, (top < 4) ? top : 4));
          end
        end
        iair_pkg::CMD_SET_LEN: begin
          pick = $urandom_range(0, 99);
          if (pick < 10) begin
            c.new_length = LW'($urandom_range(iair_pkg::CAPACITY + 1, 127));
          end else if (pick < 35) begin
            c.new_length = LW'($urandom_range(iair_pkg::CAPACITY - 2, iair_pkg::CAPACITY));
          end else begin
            c.new_length = LW'($urandom_range(0, iair_pkg::CAPACITY));
          end
        end
        default: ;
      endcase
    end
    return c;
  endfunction

  // Gap length for either side: mostly none or short, a few long.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85)         return $urandom_range(1, 3);
    if (r < 97)         return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Sender: reset, directed table, random commands, then wait for the tail.
  initial begin
    iair_pkg::in_t  item;
    iair_pkg::out_t want;
    int unsigned    gap;
    int unsigned    calm_left;
    int             total;
    int             n;
    bit             calm;

    model_len = 0;
    for (int k = 0; k < iair_pkg::CAPACITY; k++) model_store[k] = '0;

    // Directed part: empty-store rejections first, then extremes of words, length and index.
    add_row(iair_pkg::CMD_READ,      0,   0, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_BAD,   0);
    add_row(iair_pkg::CMD_REMOVE,    0,   0, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_BAD,   0);
    add_row(iair_pkg::CMD_WRITE,     0,   0, 32'h1234_5678,  0, 1, 32'h0,
            iair_pkg::ST_BAD,   0);
    add_row(iair_pkg::CMD_REM_SLICE, 0,   1, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_BAD,   0);
    add_row(iair_pkg::CMD_INSERT,    1,   0, 32'h5,          0, 1, 32'h0,
            iair_pkg::ST_BAD,   0);
    add_row(iair_pkg::CMD_SET_LEN,   0,   0, 32'h0,         65, 1, 32'h0,
            iair_pkg::ST_FULL,  0);
    add_row(CMD_SPARE_A,             0,   0, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_BAD,   0);
    add_row(CMD_SPARE_B,           127, 127, 32'hffff_ffff, 127, 1, 32'h0,
            iair_pkg::ST_BAD,   0);
    add_row(iair_pkg::CMD_SET_LEN,   0,   0, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_OK,    0);
    add_row(iair_pkg::CMD_INSERT,    0,   0, 32'h7fff_ffff,  0, 1, 32'h0,
            iair_pkg::ST_OK,    1);
    add_row(iair_pkg::CMD_INSERT,    0,   0, 32'h8000_0000,  0, 1, 32'h0,
            iair_pkg::ST_OK,    2);
    add_row(iair_pkg::CMD_READ,      0,   0, 32'h0,          0, 1, 32'h8000_0000,
            iair_pkg::ST_OK,    2);
    add_row(iair_pkg::CMD_READ,      1,   0, 32'h0,          0, 1, 32'h7fff_ffff,
            iair_pkg::ST_OK,    2);
    // lengthen to capacity: entries past the old length were cleared at reset
    add_row(iair_pkg::CMD_SET_LEN,   0,   0, 32'h0,         64, 1, 32'h0,
            iair_pkg::ST_OK,   64);
    add_row(iair_pkg::CMD_READ,     63,   0, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_OK,   64);
    add_row(iair_pkg::CMD_INSERT,   64,   0, 32'hffff_ffff,  0, 1, 32'h0,
            iair_pkg::ST_FULL, 64);
    // index check wins over the full check
    add_row(iair_pkg::CMD_INSERT,  127,   0, 32'hffff_ffff,  0, 1, 32'h0,
            iair_pkg::ST_BAD,  64);
    add_row(iair_pkg::CMD_WRITE,    63,   0, 32'hffff_ffff,  0, 1, 32'h0,
            iair_pkg::ST_OK,   64);
    add_row(iair_pkg::CMD_READ,     63,   0, 32'h0,          0, 1, 32'hffff_ffff,
            iair_pkg::ST_OK,   64);
    add_row(iair_pkg::CMD_REMOVE,    0,   0, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_OK,   63);
    add_row(iair_pkg::CMD_REM_SLICE, 5, 127, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_BAD,  63);
    add_row(iair_pkg::CMD_REM_SLICE, 5,   5, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_BAD,  63);
    add_row(iair_pkg::CMD_REM_SLICE, 0,  63, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_OK,    0);
    add_row(iair_pkg::CMD_SET_LEN,   0,   0, 32'h0,        127, 1, 32'h0,
            iair_pkg::ST_FULL,  0);
    // stale contents come back after lengthening
    add_row(iair_pkg::CMD_SET_LEN,   0,   0, 32'h0,         64, 0, 32'h0,
            iair_pkg::ST_OK,    0);
    add_row(iair_pkg::CMD_READ,     62,   0, 32'h0,          0, 0, 32'h0,
            iair_pkg::ST_OK,    0);
    add_row(iair_pkg::CMD_REMOVE,  127,   0, 32'h0,          0, 1, 32'h0,
            iair_pkg::ST_BAD,  64);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    calm      = 1'b0;
    calm_left = $urandom_range(20, 80);
    total     = directed.size() + RANDOM_ITEMS;
    for (n = 0; n < total; n++) begin
      if (n < directed.size()) item = directed[n].cmd;
      else item = random_command();

      // alternate bursts of back-to-back transfers with gappy stretches
      if (calm_left == 0) begin
        calm      = ~calm;
        calm_left = $urandom_range(20, 80);
      end
      calm_left--;

      gap = pick_gap(calm);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= item;
      // in_ready read here is the value the edge sampled
      do @(posedge clk); while (!in_ready);

      want = apply_command(item);
      if (n < directed.size() && directed[n].fixed) want = directed[n].want;
      pending_results.push_back(want);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("PASS indexed_array_insert_remove");
    end else begin
      $display("FAIL indexed_array_insert_remove");
    end
    $finish;
  end

  // Receiver: checks each result transfer against the oldest expectation and
  // stalls out_ready at random, with quiet stretches.
  initial begin
    iair_pkg::out_t want;
    int unsigned    stall_left;
    int unsigned    calm_left;
    bit             calm;

    stall_left = 0;
    calm       = 1'b1;
    calm_left  = $urandom_range(100, 400);
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result transfer with nothing expected: read_value %h status %0d length %0d",
                 out_data.read_value, out_data.status, out_data.length);
          failures++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.read_value !== want.read_value) begin
            $error("read_value: expected %h, got %h", want.read_value, out_data.read_value);
            failures++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            failures++;
          end
          if (out_data.length !== want.length) begin
            $error("length: expected %0d, got %0d", want.length, out_data.length);
            failures++;
          end
        end
      end

      if (calm_left == 0) begin
        calm      = ~calm;
        calm_left = $urandom_range(100, 400);
      end
      calm_left--;

      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        stall_left = pick_gap(calm);
        out_ready <= (stall_left == 0);
      end
    end
  end

endmodule

// ===== files.f =====
hw/rtl/iair_pkg.sv
hw/rtl/indexed_array_insert_remove.sv
sim/testbench.sv
